/* rtl/core/psce_pkg.sv */
package psce_pkg;

    // Field widths
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned EKIND_W = 3;
    localparam int unsigned OKIND_W = 3;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned GAP_W   = 10;
    localparam int unsigned CFGI_W  = 2;
    localparam int unsigned CFGD_W  = 16;
    localparam int unsigned ATT_W   = 17;
    localparam int unsigned WAIT_W  = 26;
    localparam int unsigned MUL_W   = 10;

    // Request types
    localparam logic [REQ_W-1:0] REQ_CMD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RDAT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    // Entry kinds
    localparam logic [EKIND_W-1:0] EK_READ  = 3'd0;
    localparam logic [EKIND_W-1:0] EK_WRITE = 3'd1;
    localparam logic [EKIND_W-1:0] EK_POLL  = 3'd2;
    localparam logic [EKIND_W-1:0] EK_DELAY = 3'd3;
    localparam logic [EKIND_W-1:0] EK_END   = 3'd4;

    // Result kinds
    localparam logic [OKIND_W-1:0] OUT_READY = 3'd0;
    localparam logic [OKIND_W-1:0] OUT_READ  = 3'd1;
    localparam logic [OKIND_W-1:0] OUT_WRITE = 3'd2;
    localparam logic [OKIND_W-1:0] OUT_DONE  = 3'd3;
    localparam logic [OKIND_W-1:0] OUT_FAIL  = 3'd4;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_CUT   = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_GAP   = 2'd2;

    // Reset values and constants
    localparam logic [BYTE_W-1:0]  CUT_RESET   = 8'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd5000;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 10'd10;
    localparam logic [MUL_W-1:0]   MS_TO_US    = 10'd1000;
    localparam logic [ATT_W-1:0]   ATT_MAX     = {ATT_W{1'b1}};

endpackage

/* rtl/core/power_sequence_command_engine.sv */
// Power-sequence command engine. Each accepted item (a table entry, a bus
// read-data return or a one-microsecond tick) is handled in the cycle it is
// accepted, one item per clock sustained; the only limit is the result path,
// a result register backed by a one-entry skid stage, so o_in_stall rises only
// when two results wait behind a stalled output. Write configuration through
// the plain write port only while the engine is idle, which is not enforced.
// Poll attempts are counted per sequence, cleared by a done or failure result.
module power_sequence_command_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [psce_pkg::CFGI_W-1:0]   i_cfg_index,
    input  logic [psce_pkg::CFGD_W-1:0]   i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [psce_pkg::REQ_W-1:0]    i_req_type,
    input  logic [psce_pkg::ADDR_W-1:0]   i_entry_address,
    input  logic [psce_pkg::BYTE_W-1:0]   i_entry_cut_mask,
    input  logic [psce_pkg::EKIND_W-1:0]  i_entry_kind,
    input  logic [psce_pkg::BYTE_W-1:0]   i_entry_mask,
    input  logic [psce_pkg::BYTE_W-1:0]   i_entry_value,
    input  logic [psce_pkg::BYTE_W-1:0]   i_read_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [psce_pkg::OKIND_W-1:0]  o_out_kind,
    output logic [psce_pkg::ADDR_W-1:0]   o_bus_address,
    output logic [psce_pkg::BYTE_W-1:0]   o_bus_write_data
);
    import psce_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WRITE_READ,
        PH_POLL_READ,
        PH_POLL_WAIT,
        PH_DELAY
    } t_phase;

    typedef struct packed {
        logic [OKIND_W-1:0] kind;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  data;
    } t_result;

    // configuration
    logic [BYTE_W-1:0]  r_cut_version;
    logic [LIMIT_W-1:0] r_poll_limit;
    logic [GAP_W-1:0]   r_poll_gap;

    // sequencing state
    t_phase             r_phase,    n_phase;
    logic [ATT_W-1:0]   r_attempts, n_attempts;
    logic [WAIT_W-1:0]  r_wait,     n_wait;
    logic [ADDR_W-1:0]  r_haddr,    n_haddr;
    logic [BYTE_W-1:0]  r_hmask,    n_hmask;
    logic [BYTE_W-1:0]  r_hvalue,   n_hvalue;

    // result register and skid stage
    logic               r_out_valid, r_skid_valid;
    t_result            r_out, r_skid;

    logic               accept, out_take;
    logic               res_valid;
    t_result            res;
    logic [WAIT_W-1:0]  delay_us, wait_dec;
    logic               poll_match;

    assign accept   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    assign delay_us = (i_entry_value == '0)
                      ? WAIT_W'(i_entry_address)
                      : WAIT_W'(i_entry_address) * WAIT_W'(MS_TO_US);
    assign wait_dec = (r_wait != '0) ? r_wait - 1'b1 : '0;
    assign poll_match = ((i_read_data ^ r_hvalue) & r_hmask) == '0;

    // work out the next state and the result of the incoming item
    always_comb begin
        n_phase    = r_phase;
        n_attempts = r_attempts;
        n_wait     = r_wait;
        n_haddr    = r_haddr;
        n_hmask    = r_hmask;
        n_hvalue   = r_hvalue;
        res_valid  = 1'b0;
        res        = '{kind: OUT_READY, addr: '0, data: '0};
        case (i_req_type)
            REQ_CMD: begin
                if (r_phase == PH_IDLE) begin
                    res_valid = 1'b1;
                    if ((i_entry_cut_mask & r_cut_version) != '0) begin
                        case (i_entry_kind)
                            EK_WRITE, EK_POLL: begin
                                n_haddr  = i_entry_address;
                                n_hmask  = i_entry_mask;
                                n_hvalue = i_entry_value;
                                n_phase  = (i_entry_kind == EK_WRITE) ? PH_WRITE_READ
                                                                      : PH_POLL_READ;
                                res.kind = OUT_READ;
                                res.addr = i_entry_address;
                            end
                            EK_DELAY: begin
                                n_wait = delay_us;
                                if (delay_us != '0) begin
                                    n_phase   = PH_DELAY;
                                    res_valid = 1'b0;
                                end
                            end
                            EK_END: begin
                                n_attempts = '0;
                                res.kind   = OUT_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            REQ_RDAT: begin
                if (r_phase == PH_WRITE_READ) begin
                    n_phase   = PH_IDLE;
                    res_valid = 1'b1;
                    res.kind  = OUT_WRITE;
                    res.addr  = r_haddr;
                    res.data  = (i_read_data & ~r_hmask) | (r_hvalue & r_hmask);
                end else if (r_phase == PH_POLL_READ) begin
                    if (r_attempts != ATT_MAX) begin
                        n_attempts = r_attempts + 1'b1;
                    end
                    if (r_attempts > ATT_W'(r_poll_limit)) begin
                        n_phase    = PH_IDLE;
                        n_attempts = '0;
                        res_valid  = 1'b1;
                        res.kind   = OUT_FAIL;
                    end else if (poll_match) begin
                        n_phase   = PH_IDLE;
                        res_valid = 1'b1;
                    end else if (r_poll_gap == '0) begin
                        res_valid = 1'b1;
                        res.kind  = OUT_READ;
                        res.addr  = r_haddr;
                    end else begin
                        n_wait  = WAIT_W'(r_poll_gap);
                        n_phase = PH_POLL_WAIT;
                    end
                end
            end
            REQ_TICK: begin
                if (r_phase == PH_POLL_WAIT || r_phase == PH_DELAY) begin
                    n_wait = wait_dec;
                    if (wait_dec == '0) begin
                        res_valid = 1'b1;
                        if (r_phase == PH_POLL_WAIT) begin
                            n_phase  = PH_POLL_READ;
                            res.kind = OUT_READ;
                            res.addr = r_haddr;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // hold configuration, state and the result stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_version <= CUT_RESET;
            r_poll_limit  <= LIMIT_RESET;
            r_poll_gap    <= GAP_RESET;
            r_phase       <= PH_IDLE;
            r_attempts    <= '0;
            r_wait        <= '0;
            r_haddr       <= '0;
            r_hmask       <= '0;
            r_hvalue      <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CUT:   r_cut_version <= i_cfg_data[BYTE_W-1:0];
                    CFG_LIMIT: r_poll_limit  <= i_cfg_data[LIMIT_W-1:0];
                    CFG_GAP:   r_poll_gap    <= i_cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase    <= n_phase;
                r_attempts <= n_attempts;
                r_wait     <= n_wait;
                r_haddr    <= n_haddr;
                r_hmask    <= n_hmask;
                r_hvalue   <= n_hvalue;
            end
            // advance the skid stage, else store a new result or retire one
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (accept && res_valid) begin
                if (!r_out_valid || out_take) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_out_kind       = r_out.kind;
    assign o_bus_address    = r_out.addr;
    assign o_bus_write_data = r_out.data;

endmodule

/* rtl/core/psce_checker.sv */
module psce_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [psce_pkg::OKIND_W-1:0]  o_out_kind,
    input  logic [psce_pkg::ADDR_W-1:0]   o_bus_address,
    input  logic [psce_pkg::BYTE_W-1:0]   o_bus_write_data
);
    import psce_pkg::*;

    // input stalls only while a result is already waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // stall on the input rises only behind a stalled result
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall rose without output back-pressure");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_kind)
            && $stable(o_bus_address) && $stable(o_bus_write_data))
        else $error("stalled result changed");

    // only bus requests carry an address, only writes carry data
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind != OUT_READ && o_out_kind != OUT_WRITE
            |-> o_bus_address == '0 && o_bus_write_data == '0)
        else $error("status result carries bus payload");

endmodule

bind power_sequence_command_engine psce_checker u_psce_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_kind       (o_out_kind),
    .o_bus_address    (o_bus_address),
    .o_bus_write_data (o_bus_write_data)
);
